### src/grouped_team_fifo_core_defines.svh
// assertion macros for the grouped team fifo core
`ifndef GROUPED_TEAM_FIFO_CORE_DEFINES_SVH
`define GROUPED_TEAM_FIFO_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define GTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define GTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GTF_ASSERT(lbl, prop, msg)
`define GTF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/gtf_pkg.sv
// shared constants and codes for the grouped team fifo
package gtf_pkg;

  localparam int ELEMENTS_DEF = 1024;
  localparam int TEAMS_DEF    = 16;
  localparam int CAPACITY_DEF = 256;

  localparam int KIND_W    = 2;
  localparam int ELEM_ID_W = 10;
  localparam int TEAM_ID_W = 4;
  localparam int STATUS_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ASSIGN = 2'd0,
    KIND_ENQ    = 2'd1,
    KIND_DEQ    = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

### src/gtf_ram.sv
// single write port ram with registered read and same-cycle write bypass
module gtf_ram #(
  parameter int  DEPTH = gtf_pkg::CAPACITY_DEF,
  parameter int  WIDTH = gtf_pkg::ELEM_ID_W,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] bdat_q;
  logic             byp_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q   <= mem_q[raddr_i];
      byp_q  <= we_i && (waddr_i == raddr_i);
      bdat_q <= wdata_i;
    end
  end

  assign rdata_o = byp_q ? bdat_q : rd_q;

endmodule

### src/gtf_free_list.sv
// free slot store, entries never written read back as their own index
module gtf_free_list #(
  parameter int  CAPACITY = gtf_pkg::CAPACITY_DEF,
  localparam int CW       = $clog2(CAPACITY)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [CW-1:0] waddr_i,
  input  logic [CW-1:0] wdata_i,
  input  logic [CW-1:0] raddr_i,
  output logic [CW-1:0] rdata_o
);

  logic [CAPACITY-1:0] vld_q;
  logic                vrd_q;
  logic [CW-1:0]       idx_q;
  logic [CW-1:0]       ram_rdata;

  gtf_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (CW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (1'b1),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vrd_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      vrd_q <= vld_q[raddr_i] || (we_i && (waddr_i == raddr_i));
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= raddr_i;
  end

  assign rdata_o = vrd_q ? ram_rdata : idx_q;

endmodule

### src/gtf_member_store.sv
// element to team map with clearing pass after reset
module gtf_member_store #(
  parameter int  ELEMENTS = gtf_pkg::ELEMENTS_DEF,
  parameter int  TEAMS    = gtf_pkg::TEAMS_DEF,
  localparam int EW       = $clog2(ELEMENTS),
  localparam int TW       = $clog2(TEAMS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [EW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [EW-1:0] waddr_i,
  input  logic [TW-1:0] wdata_i,
  output logic [TW-1:0] rdata_o,
  output logic          busy_o
);

  logic          clr_busy_q;
  logic [EW-1:0] clr_addr_q;
  logic          ram_we;
  logic [EW-1:0] ram_waddr;
  logic [TW-1:0] ram_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == EW'(ELEMENTS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  assign ram_we    = clr_busy_q || we_i;
  assign ram_waddr = clr_busy_q ? clr_addr_q : waddr_i;
  assign ram_wdata = clr_busy_q ? '0 : wdata_i;

  gtf_ram #(
    .DEPTH (ELEMENTS),
    .WIDTH (TW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (rdata_o)
  );

  assign busy_o = clr_busy_q;

endmodule

### src/grouped_team_fifo_core.sv
// grouped team fifo top level: input stage, queue control and result register
//
// Team queue over a shared store of CAPACITY slots. One item is accepted per
// cycle while the output side takes results; each item is held in the input
// stage register and then passes to the output register. The queue state
// (team heads, tails, group order and counts) sits in flip-flops; the slot
// store and free list are memories whose reads for the front slot and the next
// free slot are issued from the next-state pointers, and the element-to-team
// map is read as the item is accepted. After reset the team map is cleared
// entry by entry, and in_ready_o is low during the clearing pass.
`include "grouped_team_fifo_core_defines.svh"
module grouped_team_fifo_core #(
  parameter int  ELEMENTS = gtf_pkg::ELEMENTS_DEF,
  parameter int  TEAMS    = gtf_pkg::TEAMS_DEF,
  parameter int  CAPACITY = gtf_pkg::CAPACITY_DEF,
  localparam int EW       = $clog2(ELEMENTS),
  localparam int TW       = $clog2(TEAMS),
  localparam int CW       = $clog2(CAPACITY),
  localparam int GCW      = $clog2(TEAMS + 1),
  localparam int FCW      = $clog2(CAPACITY + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gtf_pkg::KIND_W-1:0]     kind_i,
  input  logic [gtf_pkg::ELEM_ID_W-1:0]  element_id_i,
  input  logic [gtf_pkg::TEAM_ID_W-1:0]  team_id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gtf_pkg::ELEM_ID_W-1:0]  element_out_o,
  output logic [gtf_pkg::STATUS_W-1:0]   status_o
);

  // input stage
  logic                          a_valid_q;
  logic [gtf_pkg::KIND_W-1:0]    a_kind_q;
  logic [gtf_pkg::ELEM_ID_W-1:0] a_elem_q;
  logic [TW-1:0]                 a_team_q;
  logic                          a_in_range_q;

  // result register
  logic                          out_valid_q;
  logic [gtf_pkg::ELEM_ID_W-1:0] out_elem_q;
  logic [gtf_pkg::STATUS_W-1:0]  out_status_q;

  // queue state
  logic [TEAMS-1:0] team_waiting_q, team_waiting_d;
  logic [CW-1:0]    team_head_q [TEAMS];
  logic [CW-1:0]    team_tail_q [TEAMS];
  logic [TW-1:0]    group_order_q [TEAMS];
  logic [CW-1:0]    free_head_q, free_head_d;
  logic [CW-1:0]    free_tail_q, free_tail_d;
  logic [FCW-1:0]   free_count_q, free_count_d;
  logic [TW-1:0]    group_rptr_q, group_rptr_d;
  logic [TW-1:0]    group_wptr_q, group_wptr_d;
  logic [GCW-1:0]   group_count_q, group_count_d;
  logic [TW-1:0]    front_team_q, front_team_d;
  logic [CW-1:0]    front_slot_q, front_slot_d;

  logic          advance;
  logic          fire_a;
  logic          accept;
  logic          clr_busy;
  logic [TW-1:0] team_mod;
  logic          elem_in_range;

  logic [TW-1:0]                 member_rd;
  logic [TW-1:0]                 enq_team;
  logic [TW-1:0]                 lk_team;
  logic [CW-1:0]                 lk_tail;
  logic                          lk_waiting;
  logic [gtf_pkg::ELEM_ID_W-1:0] front_elem;
  logic [CW-1:0]                 front_link;
  logic [CW-1:0]                 free_slot;

  logic                          mem_we;
  logic                          head_we, tail_we, order_we;
  logic [TW-1:0]                 head_team, tail_team;
  logic [CW-1:0]                 head_data, tail_data;
  logic                          elem_we, link_we, free_we;
  logic [CW-1:0]                 link_waddr;

  logic [gtf_pkg::ELEM_ID_W-1:0] res_elem;
  gtf_pkg::status_e              res_status;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire_a     = a_valid_q && advance;
  assign in_ready_o = !clr_busy && (!a_valid_q || advance);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    team_mod = '0;
    for (int v = 0; v < (1 << gtf_pkg::TEAM_ID_W); v++) begin
      if (team_id_i == gtf_pkg::TEAM_ID_W'(v)) begin
        team_mod = TW'(v % TEAMS);
      end
    end
  end

  assign elem_in_range = (32'(element_id_i) < ELEMENTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_kind_q     <= kind_i;
      a_elem_q     <= element_id_i;
      a_team_q     <= team_mod;
      a_in_range_q <= elem_in_range;
    end
  end

  gtf_member_store #(
    .ELEMENTS (ELEMENTS),
    .TEAMS    (TEAMS)
  ) u_member (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (EW'(element_id_i)),
    .we_i    (mem_we),
    .waddr_i (EW'(a_elem_q)),
    .wdata_i (a_team_q),
    .rdata_o (member_rd),
    .busy_o  (clr_busy)
  );

  gtf_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (gtf_pkg::ELEM_ID_W)
  ) u_slot_elem (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (free_slot),
    .wdata_i (a_elem_q),
    .re_i    (1'b1),
    .raddr_i (front_slot_d),
    .rdata_o (front_elem)
  );

  gtf_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (CW)
  ) u_slot_link (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (free_slot),
    .re_i    (1'b1),
    .raddr_i (front_slot_d),
    .rdata_o (front_link)
  );

  gtf_free_list #(
    .CAPACITY (CAPACITY)
  ) u_free (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (free_we),
    .waddr_i (free_tail_q),
    .wdata_i (front_slot_q),
    .raddr_i (free_head_d),
    .rdata_o (free_slot)
  );

  assign enq_team   = a_in_range_q ? member_rd : '0;
  assign lk_team    = (a_kind_q == gtf_pkg::KIND_DEQ) ? front_team_q : enq_team;
  assign lk_tail    = team_tail_q[lk_team];
  assign lk_waiting = team_waiting_q[lk_team];
  assign link_waddr = lk_tail;

  always_comb begin
    team_waiting_d = team_waiting_q;
    free_head_d    = free_head_q;
    free_tail_d    = free_tail_q;
    free_count_d   = free_count_q;
    group_rptr_d   = group_rptr_q;
    group_wptr_d   = group_wptr_q;
    group_count_d  = group_count_q;
    mem_we         = 1'b0;
    head_we        = 1'b0;
    tail_we        = 1'b0;
    order_we       = 1'b0;
    head_team      = lk_team;
    tail_team      = lk_team;
    head_data      = free_slot;
    tail_data      = free_slot;
    elem_we        = 1'b0;
    link_we        = 1'b0;
    free_we        = 1'b0;
    res_elem       = '0;
    res_status     = gtf_pkg::ST_DONE;
    if (fire_a) begin
      case (a_kind_q)
        gtf_pkg::KIND_ASSIGN: begin
          mem_we = a_in_range_q;
        end
        gtf_pkg::KIND_ENQ: begin
          if (free_count_q == '0) begin
            res_status = gtf_pkg::ST_FULL;
          end else begin
            free_head_d  = (free_head_q == CW'(CAPACITY - 1)) ? '0 : free_head_q + 1'b1;
            free_count_d = free_count_q - 1'b1;
            elem_we      = 1'b1;
            tail_we      = 1'b1;
            if (lk_waiting) begin
              link_we = 1'b1;
            end else begin
              head_we                 = 1'b1;
              order_we                = 1'b1;
              team_waiting_d[lk_team] = 1'b1;
              group_wptr_d  = (group_wptr_q == TW'(TEAMS - 1)) ? '0 : group_wptr_q + 1'b1;
              group_count_d = group_count_q + 1'b1;
            end
          end
        end
        gtf_pkg::KIND_DEQ: begin
          if (group_count_q == '0) begin
            res_status = gtf_pkg::ST_EMPTY;
          end else begin
            res_elem     = front_elem;
            res_status   = gtf_pkg::ST_DEQ;
            free_we      = 1'b1;
            free_tail_d  = (free_tail_q == CW'(CAPACITY - 1)) ? '0 : free_tail_q + 1'b1;
            free_count_d = free_count_q + 1'b1;
            if (front_slot_q == lk_tail) begin
              team_waiting_d[lk_team] = 1'b0;
              group_rptr_d  = (group_rptr_q == TW'(TEAMS - 1)) ? '0 : group_rptr_q + 1'b1;
              group_count_d = group_count_q - 1'b1;
            end else begin
              head_we   = 1'b1;
              head_data = front_link;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // front of queue for next cycle, with bypass of this cycle's writes
  always_comb begin
    if (order_we && (group_wptr_q == group_rptr_d)) begin
      front_team_d = lk_team;
    end else begin
      front_team_d = group_order_q[group_rptr_d];
    end
    if (head_we && (head_team == front_team_d)) begin
      front_slot_d = head_data;
    end else begin
      front_slot_d = team_head_q[front_team_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      team_waiting_q <= '0;
      free_head_q    <= '0;
      free_tail_q    <= '0;
      free_count_q   <= FCW'(CAPACITY);
      group_rptr_q   <= '0;
      group_wptr_q   <= '0;
      group_count_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      team_waiting_q <= team_waiting_d;
      free_head_q    <= free_head_d;
      free_tail_q    <= free_tail_d;
      free_count_q   <= free_count_d;
      group_rptr_q   <= group_rptr_d;
      group_wptr_q   <= group_wptr_d;
      group_count_q  <= group_count_d;
      if (advance) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    front_team_q <= front_team_d;
    front_slot_q <= front_slot_d;
    if (head_we) begin
      team_head_q[head_team] <= head_data;
    end
    if (tail_we) begin
      team_tail_q[tail_team] <= tail_data;
    end
    if (order_we) begin
      group_order_q[group_wptr_q] <= lk_team;
    end
    if (fire_a) begin
      out_elem_q   <= res_elem;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign element_out_o = out_elem_q;
  assign status_o      = out_status_q;

  `GTF_ASSERT(a_groups_match_waiting, $countones(team_waiting_q) == group_count_q, "group count differs from waiting teams")
  `GTF_ASSERT(a_free_count_bound, free_count_q <= FCW'(CAPACITY), "free count above capacity")
  `GTF_ASSERT(a_no_accept_in_clear, !clr_busy || !in_ready_o, "ready during clearing pass")
  `GTF_ASSERT_NEXT(a_empty_dequeue, fire_a && (a_kind_q == gtf_pkg::KIND_DEQ) && (group_count_q == '0), out_valid_q && (out_status_q == gtf_pkg::ST_EMPTY), "empty dequeue not flagged")

endmodule
